### rtl/slvd_pkg.sv
// slvd_pkg: shared types and constants of the strap length, velocity and direction core
// no dependencies; used by every module in rtl/
`default_nettype none
package slvd_pkg;

	localparam int unsigned COORD_W = 32;       // Q16.16 coordinate
	localparam int unsigned MAG_W   = 32;       // |insertion - origin| per axis
	localparam int unsigned DIR_W   = 16;       // Q1.14 direction
	localparam int unsigned DIR_FRAC = 14;
	localparam int unsigned AXES    = 3;
	localparam int unsigned QUEUE_DEPTH = 2;

	// one classified transaction handed from front to back
	typedef struct packed {
		logic [AXES-1:0]             neg;
		logic [AXES-1:0][MAG_W-1:0]  mag;
	} item_t;

	// one finished result
	typedef struct packed {
		logic [31:0]                   length;
		logic [31:0]                   velocity;
		logic [AXES-1:0][DIR_W-1:0]    odir;
		logic [AXES-1:0][DIR_W-1:0]    idir;
		logic                          fixup;
	} res_t;

endpackage
`default_nettype wire

### rtl/slvd_front.sv
// slvd_front: accepts input transactions, forms per-axis differences as sign and magnitude
// depends on slvd_pkg
`default_nettype none
module slvd_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [31:0]           origin_x,
	input  wire logic signed [31:0]           origin_y,
	input  wire logic signed [31:0]           origin_z,
	input  wire logic signed [31:0]           insertion_x,
	input  wire logic signed [31:0]           insertion_y,
	input  wire logic signed [31:0]           insertion_z,
	output logic                              push,
	input  wire logic                         q_full,
	output slvd_pkg::item_t                   item
);
	logic                  v_s1;
	slvd_pkg::item_t       item_s1;
	slvd_pkg::item_t       item_d;
	logic signed [32:0]    dx, dy, dz;
	logic                  accept;

	assign dx = 33'(insertion_x) - 33'(origin_x);
	assign dy = 33'(insertion_y) - 33'(origin_y);
	assign dz = 33'(insertion_z) - 33'(origin_z);

	// magnitude always fits 32 bits: the difference stays within +-(2^32-1)
	always_comb begin
		item_d.neg = {dz[32], dy[32], dx[32]};
		item_d.mag[0] = dx[32] ? 32'(-dx) : dx[31:0];
		item_d.mag[1] = dy[32] ? 32'(-dy) : dy[31:0];
		item_d.mag[2] = dz[32] ? 32'(-dz) : dz[31:0];
	end

	assign in_stall = v_s1 & q_full;
	assign accept   = in_valid & ~in_stall;
	assign push     = v_s1 & ~q_full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end
endmodule
`default_nettype wire

### rtl/slvd_queue.sv
// slvd_queue: short queue of classified transactions between front and back
// depends on slvd_pkg
`default_nettype none
module slvd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire slvd_pkg::item_t wr_item,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output slvd_pkg::item_t      rd_item
);
	slvd_pkg::item_t   mem_q [slvd_pkg::QUEUE_DEPTH];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;

	assign full      = (cnt_q == 2'(slvd_pkg::QUEUE_DEPTH));
	assign not_empty = (cnt_q != 2'd0);
	assign rd_item   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_item;
		end
	end
endmodule
`default_nettype wire

### rtl/slvd_back.sv
// slvd_back: sequential engine: sum of squares, square root, velocity and direction division
// depends on slvd_pkg
`default_nettype none
module slvd_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [31:0]     time_step,
	input  wire logic            q_not_empty,
	input  wire slvd_pkg::item_t q_item,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output slvd_pkg::res_t       res
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_PREP = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]            st_q;
	logic [5:0]            cnt_q;
	slvd_pkg::item_t       it_q;
	logic [63:0]           prod_q;
	logic [65:0]           acc_q;
	logic [33:0]           rem_q;
	logic [32:0]           root_q;
	logic [31:0]           prev_q;
	logic                  havep_q;
	logic [31:0]           len32_q;
	logic                  fixup_q;
	logic                  vact_q, vneg_q, vsat_q;
	logic [32:0]           vr_q;
	logic [31:0]           vq_q;
	logic [46:0]           nr_q [slvd_pkg::AXES];
	logic [46:0]           dv_q;
	logic [14:0]           dq_q [slvd_pkg::AXES];
	logic                  out_valid_q;
	slvd_pkg::res_t        res_q;

	logic [31:0]           mag_sel;
	logic [35:0]           rem_sh, trial;
	logic [31:0]           len32;
	logic [32:0]           diff;
	logic [31:0]           vmag;
	logic [33:0]           vt;
	logic [32:0]           q33;
	logic [31:0]           vel;
	slvd_pkg::res_t        res_d;
	logic                  load;

	assign pop = (st_q == ST_IDLE) & q_not_empty;
	assign load = (st_q == ST_DONE) & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;
	assign res = res_q;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: mag_sel = it_q.mag[0];
			2'd1: mag_sel = it_q.mag[1];
			2'd2: mag_sel = it_q.mag[2];
			default: mag_sel = '0;
		endcase
	end

	// one root digit per cycle, two radicand bits at a time
	assign rem_sh = {rem_q, acc_q[65:64]};
	assign trial  = {1'b0, root_q, 2'b01};

	assign len32 = root_q[32] ? 32'hFFFF_FFFF : root_q[31:0];
	assign diff  = {1'b0, len32} - {1'b0, prev_q};
	assign vmag  = diff[32] ? 32'(-diff) : diff[31:0];
	assign vt    = {vr_q, 1'b0};

	always_comb begin
		q33 = vsat_q ? 33'h1_0000_0000 : {1'b0, vq_q};
		if (!vact_q) vel = '0;
		else if (!vneg_q) vel = (q33 > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q33[31:0];
		else vel = (q33 > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-q33);
		res_d.length   = len32_q;
		res_d.velocity = vel;
		res_d.fixup    = fixup_q;
		for (int k = 0; k < slvd_pkg::AXES; k++) begin
			if (fixup_q) res_d.odir[k] = '0;
			else if (it_q.neg[k]) res_d.odir[k] = -{1'b0, dq_q[k]};
			else res_d.odir[k] = {1'b0, dq_q[k]};
			res_d.idir[k] = -res_d.odir[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			prev_q      <= '0;
			havep_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (q_not_empty) begin
						st_q  <= ST_SQ;
						cnt_q <= '0;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd3) begin
						st_q  <= ST_ROOT;
						cnt_q <= '0;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) st_q <= ST_PREP;
				end
				ST_PREP: begin
					prev_q  <= len32;
					havep_q <= 1'b1;
					cnt_q   <= '0;
					st_q    <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				it_q  <= q_item;
				acc_q <= '0;
			end
			ST_SQ: begin
				if (cnt_q != 6'd3) prod_q <= mag_sel * mag_sel;
				if (cnt_q != 6'd0) acc_q <= acc_q + 66'(prod_q);
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				acc_q <= {acc_q[63:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= 34'(rem_sh - trial);
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					rem_q  <= rem_sh[33:0];
					root_q <= {root_q[31:0], 1'b0};
				end
			end
			ST_PREP: begin
				len32_q <= len32;
				fixup_q <= (root_q == '0);
				vact_q  <= havep_q & (time_step != '0);
				vneg_q  <= diff[32];
				vsat_q  <= (vmag >= time_step);
				vr_q    <= {1'b0, vmag};
				dv_q    <= {root_q, 14'b0};
				for (int k = 0; k < slvd_pkg::AXES; k++) begin
					nr_q[k] <= {1'b0, it_q.mag[k], 14'b0} + {15'b0, root_q[32:1]};
				end
			end
			ST_DIV: begin
				if (vt >= {2'b00, time_step}) begin
					vr_q <= 33'(vt - {2'b00, time_step});
					vq_q <= {vq_q[30:0], 1'b1};
				end else begin
					vr_q <= vt[32:0];
					vq_q <= {vq_q[30:0], 1'b0};
				end
				if (cnt_q <= 6'(slvd_pkg::DIR_FRAC)) begin
					dv_q <= {1'b0, dv_q[46:1]};
					for (int k = 0; k < slvd_pkg::AXES; k++) begin
						if (nr_q[k] >= dv_q) begin
							nr_q[k] <= nr_q[k] - dv_q;
							dq_q[k] <= {dq_q[k][13:0], 1'b1};
						end else begin
							dq_q[k] <= {dq_q[k][13:0], 1'b0};
						end
					end
				end
			end
			ST_DONE: begin
				if (load) res_q <= res_d;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### rtl/strap_length_velocity_direction_core.sv
// strap_length_velocity_direction_core: top level, configuration port and result ports
// depends on slvd_pkg, slvd_front, slvd_queue, slvd_back
`default_nettype none
// Computes, for each transaction of two Q16.16 points, the strap length (floor of the
// Euclidean distance, saturating), its rate of change against the previous transaction's
// length divided by time_step (truncated, saturating; zero on the first transaction after
// reset or when time_step is zero) and the Q1.14 unit direction, rounded half away from
// zero, with its negation. Coincident points give zero directions and raise
// direction_fixup. In the back engine a transaction is taken from the queue, its squares
// are summed through a single 32x32 multiplier, then come the bit-serial square root, a
// setup step, the shift-subtract velocity division (the three direction divisions run
// beside it) and the handover of the result. The front register and a two-entry queue
// keep taking transactions while the engine is busy, and a result register lets the next
// transaction start while a result waits.
// time_step must only be written while idle.
module strap_length_velocity_direction_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	// input channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic signed [31:0]  origin_x,
	input  wire logic signed [31:0]  origin_y,
	input  wire logic signed [31:0]  origin_z,
	input  wire logic signed [31:0]  insertion_x,
	input  wire logic signed [31:0]  insertion_y,
	input  wire logic signed [31:0]  insertion_z,
	// output channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [31:0]              strap_length,
	output logic signed [31:0]       strap_velocity,
	output logic signed [15:0]       origin_dir_x,
	output logic signed [15:0]       origin_dir_y,
	output logic signed [15:0]       origin_dir_z,
	output logic signed [15:0]       insertion_dir_x,
	output logic signed [15:0]       insertion_dir_y,
	output logic signed [15:0]       insertion_dir_z,
	output logic                     direction_fixup
);
	logic [31:0]          time_step_q;
	logic                 push, q_full, q_not_empty, pop;
	slvd_pkg::item_t      f_item, q_item;
	slvd_pkg::res_t       res;
	logic                 ts_sel;

	// time_step is the only register, at byte address zero
	assign ts_sel = (paddr == 3'd0);
	assign pready = 1'b1;
	assign prdata = ts_sel ? time_step_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= '0;
		end else if (psel && penable && pwrite && ts_sel) begin
			time_step_q <= pwdata;
		end
	end

	// front: capture and split differences into sign and magnitude
	slvd_front u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.origin_x, .origin_y, .origin_z,
		.insertion_x, .insertion_y, .insertion_z,
		.push, .q_full, .item(f_item)
	);

	// decoupling queue
	slvd_queue u_queue (
		.clk, .arst_n, .push, .wr_item(f_item), .full(q_full),
		.pop, .not_empty(q_not_empty), .rd_item(q_item)
	);

	// back: iterative arithmetic and result register
	slvd_back u_back (
		.clk, .arst_n, .time_step(time_step_q),
		.q_not_empty, .q_item, .pop,
		.out_valid, .out_stall, .res
	);

	assign strap_length    = res.length;
	assign strap_velocity  = res.velocity;
	assign origin_dir_x    = res.odir[0];
	assign origin_dir_y    = res.odir[1];
	assign origin_dir_z    = res.odir[2];
	assign insertion_dir_x = res.idir[0];
	assign insertion_dir_y = res.idir[1];
	assign insertion_dir_z = res.idir[2];
	assign direction_fixup = res.fixup;

`ifndef SYNTHESIS
	// coincident points give zero directions
	a_fixup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && direction_fixup) |-> (origin_dir_x == 0 && origin_dir_y == 0
			&& origin_dir_z == 0))
		else $error("fixup with non-zero direction");
	// insertion direction is the negated origin direction
	a_negated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (insertion_dir_x == -origin_dir_x && insertion_dir_y == -origin_dir_y
			&& insertion_dir_z == -origin_dir_z))
		else $error("insertion direction not negated");
	// x component of the unit direction stays within one in Q1.14
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (origin_dir_x <= 16'sd16384 && origin_dir_x >= -16'sd16384))
		else $error("direction out of range");
`endif
endmodule
`default_nettype wire

### verif/tb_top.sv
// tb_top: self-checking testbench of the strap length, velocity and direction core
// depends on rtl/slvd_pkg.sv and rtl/strap_length_velocity_direction_core.sv
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// register addresses on the configuration port
	localparam logic [2:0] ADDR_TIME_STEP = 3'd0;
	localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;

	localparam int DRAIN_CYCLES = 200;   // comfortably above one engine pass
	localparam int LONG_HOLD    = 400;

	// one expected result, field by field
	typedef struct {
		logic [31:0]        length;
		logic signed [31:0] velocity;
		logic signed [15:0] odir [3];
		logic signed [15:0] idir [3];
		logic               fixup;
	} strap_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [31:0] insertion_x = '0, insertion_y = '0, insertion_z = '0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] strap_length;
	logic signed [31:0] strap_velocity;
	logic signed [15:0] origin_dir_x, origin_dir_y, origin_dir_z;
	logic signed [15:0] insertion_dir_x, insertion_dir_y, insertion_dir_z;
	logic        direction_fixup;

	// predictor state, mirroring the core
	logic [31:0] step_reg = '0;
	logic [31:0] last_length = '0;
	logic        seen_length = 1'b0;

	strap_res_t expected_results[$];
	int err_count = 0;
	int hold_request = 0;   // long receiver hold-off, in cycles
	bit quiet_phase = 0;    // no idling on either side

	strap_length_velocity_direction_core u_dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall,
		.origin_x, .origin_y, .origin_z, .insertion_x, .insertion_y, .insertion_z,
		.out_valid, .out_stall,
		.strap_length, .strap_velocity,
		.origin_dir_x, .origin_dir_y, .origin_dir_z,
		.insertion_dir_x, .insertion_dir_y, .insertion_dir_z,
		.direction_fixup
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// floor square root of a sum of three squares (below 2^66)
	function automatic logic [33:0] floor_sqrt(input logic [65:0] v);
		logic [67:0] rem, trial;
		logic [33:0] root;
		rem = '0;
		root = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | v[2*i +: 2];
			trial = ({34'd0, root} << 2) | 68'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 34'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	// expected result of one transaction; advances the predictor state
	function automatic strap_res_t predict_strap(input logic signed [31:0] o[3],
			input logic signed [31:0] p[3]);
		strap_res_t r;
		longint dl [3];
		logic [65:0] sumsq;
		logic [63:0] m, q, diffmag;
		logic [33:0] full_len;
		logic [31:0] len32;
		longint diff, u;
		sumsq = '0;
		for (int k = 0; k < 3; k++) begin
			dl[k] = longint'(p[k]) - longint'(o[k]);
			m = (dl[k] < 0) ? 64'(-dl[k]) : 64'(dl[k]);
			sumsq = sumsq + 66'(m) * 66'(m);
		end
		full_len = floor_sqrt(sumsq);
		len32 = (full_len > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : full_len[31:0];

		r.velocity = '0;
		if (seen_length && step_reg != 0) begin
			diff = longint'(len32) - longint'(last_length);
			diffmag = (diff < 0) ? 64'(-diff) : 64'(diff);
			if (diffmag >= 64'(step_reg)) q = 64'h1_0000_0000;
			else q = (diffmag << 32) / 64'(step_reg);
			if (diff >= 0) r.velocity = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
			else r.velocity = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(q));
		end
		last_length = len32;
		seen_length = 1'b1;

		r.length = len32;
		r.fixup = (full_len == 0);
		for (int k = 0; k < 3; k++) begin
			u = 0;
			if (!r.fixup) begin
				m = (dl[k] < 0) ? 64'(-dl[k]) : 64'(dl[k]);
				q = (m * 64'd16384 + 64'(full_len) / 2) / 64'(full_len);
				u = (dl[k] < 0) ? -longint'(q) : longint'(q);
			end
			r.odir[k] = 16'(u);
			r.idir[k] = 16'(-u);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		err_count++;
		if (err_count <= 30)
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (quiet_phase) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one transaction, wait for acceptance, record what it should produce
	task automatic send_item(input logic signed [31:0] o[3], input logic signed [31:0] p[3]);
		int gap;
		@(negedge clk);
		origin_x = o[0]; origin_y = o[1]; origin_z = o[2];
		insertion_x = p[0]; insertion_y = p[1]; insertion_z = p[2];
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		expected_results.insert(expected_results.size(), predict_strap(o, p));
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// lower valid and wait until every outstanding result has come out
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_TIME_STEP) step_reg = data;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic apb_check_read(input logic [2:0] addr, input logic [31:0] want);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b0; penable = 1'b0; paddr = addr;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) report_mismatch("time_step readback", prdata, want);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
	endtask

	task automatic set_time_step(input logic [31:0] v);
		apb_write(ADDR_TIME_STEP, v);
		apb_check_read(ADDR_TIME_STEP, v);
	endtask

	// random points: wide spreads, near points, coincident points, extremes
	task automatic send_random_item();
		logic signed [31:0] o[3], p[3];
		int mode;
		mode = $urandom_range(0, 99);
		for (int k = 0; k < 3; k++) begin
			o[k] = $urandom;
			if (mode < 20) p[k] = $urandom;
			else if (mode < 75) p[k] = o[k] + $signed($urandom_range(0, 8191)) - 4096;
			else if (mode < 90) p[k] = o[k] + $signed($urandom_range(0, 2000000)) - 1000000;
			else if (mode < 95) p[k] = o[k];
			else begin
				o[k] = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				p[k] = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end
		end
		send_item(o, p);
	endtask

	// extremes, first transaction after reset, coincident and saturating cases
	task automatic test_directed();
		logic signed [31:0] o[3], p[3];
		// first transaction after reset: velocity is zero even with a step set
		set_time_step(32'd65536);
		o = '{0, 0, 0}; p = '{32'sh0003_0000, 32'sh0004_0000, 0};
		send_item(o, p);
		// coincident points: zero directions and fixup raised
		o = '{32'sh1234_5678, -32'sh0000_1000, 32'sh7FFF_FFFF};
		send_item(o, o);
		// single axis directions, each sign
		o = '{0, 0, 0}; p = '{32'sh0001_0000, 0, 0}; send_item(o, p);
		p = '{0, -32'sh0001_0000, 0}; send_item(o, p);
		p = '{0, 0, 1}; send_item(o, p);
		p = '{-1, 0, 0}; send_item(o, p);
		// length beyond range on every axis, then the largest swing back
		o = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		send_item(o, p);
		send_item(p, o);
		o = '{0, 0, 0}; p = '{0, 0, 0}; send_item(o, p);
		// half-way rounding and uneven directions
		p = '{1, 1, 1}; send_item(o, p);
		p = '{3, -4, 12}; send_item(o, p);
		p = '{-32'sh7FFF_FFFF, 5, -7}; send_item(o, p);
		wait_idle();
		// zero step forces velocity zero
		set_time_step(32'd0);
		p = '{32'sh0010_0000, 0, 0}; send_item(o, p);
		p = '{32'sh0020_0000, 0, 0}; send_item(o, p);
		wait_idle();
		// smallest step: every change saturates
		set_time_step(32'd1);
		p = '{32'sh0010_0000, 0, 0}; send_item(o, p);
		p = '{32'sh0010_0000, 0, 0}; send_item(o, p);
		p = '{2, 0, 0}; send_item(o, p);
		wait_idle();
		// largest step
		set_time_step(32'hFFFF_FFFF);
		p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0}; send_item(o, p);
		p = '{1, 0, 0}; send_item(o, p);
		wait_idle();
	endtask

	// an unmapped address must not disturb time_step
	task automatic test_unmapped_write();
		logic signed [31:0] o[3], p[3];
		set_time_step(32'd4294967);
		apb_write(ADDR_UNMAPPED, 32'd7);
		apb_check_read(ADDR_TIME_STEP, 32'd4294967);
		o = '{0, 0, 0}; p = '{32'sh0000_8000, 0, 0}; send_item(o, p);
		p = '{32'sh0001_0000, 0, 0}; send_item(o, p);
		wait_idle();
	endtask

	task automatic test_random(input logic [31:0] step, input int count);
		set_time_step(step);
		for (int i = 0; i < count; i++) send_random_item();
		wait_idle();
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		hold_request = LONG_HOLD;
		quiet_phase = 1;
		for (int i = 0; i < 40; i++) send_random_item();
		quiet_phase = 0;
		wait_idle();
	endtask

	// receiver: random stall, or a long hold when one is asked for
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				out_stall = 1'b1;
				hold_request--;
			end else if (quiet_phase) begin
				out_stall = 1'b0;
			end else begin
				out_stall = (pick_gap() > 0) && ($urandom_range(0, 3) == 0);
			end
		end
	end

	// compare each delivered result with the oldest expectation
	always @(posedge clk) begin
		strap_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", strap_length, 0);
			end else begin
				e = expected_results.pop_front();
				if (strap_length !== e.length)
					report_mismatch("strap_length", strap_length, e.length);
				if (strap_velocity !== e.velocity)
					report_mismatch("strap_velocity", strap_velocity, e.velocity);
				if (origin_dir_x !== e.odir[0]) report_mismatch("origin_dir_x", origin_dir_x, e.odir[0]);
				if (origin_dir_y !== e.odir[1]) report_mismatch("origin_dir_y", origin_dir_y, e.odir[1]);
				if (origin_dir_z !== e.odir[2]) report_mismatch("origin_dir_z", origin_dir_z, e.odir[2]);
				if (insertion_dir_x !== e.idir[0])
					report_mismatch("insertion_dir_x", insertion_dir_x, e.idir[0]);
				if (insertion_dir_y !== e.idir[1])
					report_mismatch("insertion_dir_y", insertion_dir_y, e.idir[1]);
				if (insertion_dir_z !== e.idir[2])
					report_mismatch("insertion_dir_z", insertion_dir_z, e.idir[2]);
				if (direction_fixup !== e.fixup)
					report_mismatch("direction_fixup", direction_fixup, e.fixup);
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_unmapped_write();
		test_random(32'd4294967, 300);
		test_backpressure();
		test_random(32'd0, 150);
		test_random(32'd1, 150);
		test_random($urandom, 250);
		test_random(32'hFFFF_FFFF, 150);
		test_random(32'd65536, 150);
		if (expected_results.size() != 0)
			report_mismatch("results never delivered", expected_results.size(), 0);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire

### strap_length_velocity_direction_core.f
rtl/slvd_pkg.sv
rtl/slvd_front.sv
rtl/slvd_queue.sv
rtl/slvd_back.sv
rtl/strap_length_velocity_direction_core.sv
verif/tb_top.sv
